@@ sv/hfi_pkg.sv @@
// Types, constants and coding functions shared by the FEC interleave encoder.
package hfi_pkg;

  localparam int unsigned BLOCK_BYTES = 12;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned FILL_W      = 4;
  localparam int unsigned CFG_IDX_W   = 2;

  typedef logic [BYTE_W-1:0]                   byte_t;
  typedef logic [FILL_W-1:0]                   fill_t;
  typedef logic [CFG_IDX_W-1:0]                cfg_idx_t;
  typedef logic [BLOCK_BYTES-1:0][BYTE_W-1:0]  blk_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_FLAG   = 2'd0;
  localparam cfg_idx_t CFG_RESET  = 2'd1;
  localparam cfg_idx_t CFG_ESCAPE = 2'd2;
  localparam cfg_idx_t CFG_ILV    = 2'd3;

  // Configuration reset values.
  localparam byte_t FLAG_RST   = 8'd126;
  localparam byte_t RESET_RST  = 8'd127;
  localparam byte_t ESCAPE_RST = 8'd27;
  localparam logic  ILV_RST    = 1'b1;

  localparam fill_t LAST_POS   = fill_t'(BLOCK_BYTES - 1);
  localparam fill_t BLOCK_CNT  = fill_t'(BLOCK_BYTES);

  // Block positions that hold data bytes; the others hold parity.
  localparam fill_t DATA_POS [8] = '{4'd0, 4'd1, 4'd3, 4'd4, 4'd6, 4'd7, 4'd9, 4'd10};

  typedef struct packed {
    byte_t data_byte;
    logic  frame_start;
  } in_beat_t;

  typedef struct packed {
    byte_t line_byte;
    logic  run_last;
  } out_beat_t;

  typedef struct packed {
    byte_t flag_value;
    byte_t reset_value;
    byte_t escape_value;
    logic  interleave_on;
  } cfg_t;

  // Four Hamming parity bits of one data byte.
  function automatic logic [3:0] nibble_parity(byte_t d);
    nibble_parity = {d[4] ^ d[5] ^ d[6] ^ d[7],
                     d[1] ^ d[2] ^ d[3] ^ d[7],
                     d[0] ^ d[2] ^ d[3] ^ d[5] ^ d[6],
                     d[0] ^ d[1] ^ d[3] ^ d[4] ^ d[6]};
  endfunction

  // Parity byte of a pair: first byte in the low nibble, second in the high.
  function automatic byte_t pair_parity(byte_t lo, byte_t hi);
    pair_parity = {nibble_parity(hi), nibble_parity(lo)};
  endfunction

  // Bit interleave of one block; pure wiring.
  function automatic blk_t interleave(blk_t b);
    blk_t r;
    r = '0;
    for (int n = 0; n < 8; n++) begin
      for (int m = 0; m < 8; m++) begin
        r[n][7-m] = b[DATA_POS[m]][7-n];
      end
    end
    for (int j = 0; j < 4; j++) begin
      for (int m = 0; m < 4; m++) begin
        r[8+j][7-2*m] = b[3*m+2][7-j];
        r[8+j][6-2*m] = b[3*m+2][3-j];
      end
    end
    interleave = r;
  endfunction

endpackage

@@ sv/hfi_in_if.sv @@
// Valid/ready channel that carries input data beats.
interface hfi_in_if;
  import hfi_pkg::*;

  logic     valid;
  logic     ready;
  in_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/hfi_out_if.sv @@
// Valid/ready channel that carries line byte beats.
interface hfi_out_if;
  import hfi_pkg::*;

  logic      valid;
  logic      ready;
  out_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/hfi_fill.sv @@
// Parity generation and block assembly; hands each finished block to the sender.
module hfi_fill (
  input  logic          clk_i,
  input  logic          rst_ni,
  hfi_in_if.sink        in_i,
  input  logic          interleave_on_i,
  output hfi_pkg::blk_t blk_o,
  output logic          blk_valid_o,
  input  logic          blk_take_i
);
  import hfi_pkg::*;

  blk_t  store_q, view, data_view, blk_src;
  blk_t  blk_q, blk_d;
  logic  blk_valid_q, blk_valid_d;
  fill_t fill_q, fill_d;
  logic  tog_q, tog_d;
  byte_t held_q, held_d;

  logic  accept;
  fill_t fill0, fill1, fill2;
  logic  tog0, data_done, par_done;
  byte_t d, par;

  // A finished block may only enter an empty or draining hand-off register.
  assign in_i.ready = !blk_valid_q || blk_take_i;
  assign accept     = in_i.valid && in_i.ready;
  assign d          = in_i.payload.data_byte;

  // Fill positions for the data byte and the optional parity byte.
  always_comb begin
    fill0     = in_i.payload.frame_start ? '0 : fill_q;
    tog0      = in_i.payload.frame_start ? 1'b0 : tog_q;
    data_done = (fill0 == LAST_POS);
    fill1     = data_done ? '0 : fill0 + fill_t'(1);
    par       = pair_parity(held_q, d);
    par_done  = tog0 && (fill1 == LAST_POS);
    if (tog0) begin
      fill2 = par_done ? '0 : fill1 + fill_t'(1);
    end else begin
      fill2 = fill1;
    end
  end

  // Block contents as they stand after this beat's writes, and after the data byte alone.
  always_comb begin
    for (int k = 0; k < BLOCK_BYTES; k++) begin
      if (fill0 == fill_t'(k)) begin
        data_view[k] = d;
      end else begin
        data_view[k] = store_q[k];
      end
      if (tog0 && (fill1 == fill_t'(k))) begin
        view[k] = par;
      end else begin
        view[k] = data_view[k];
      end
    end
  end

  // When the data byte closes the block, its parity byte belongs to the next block.
  assign blk_src = data_done ? data_view : view;

  // Next state of the control registers and the hand-off register.
  always_comb begin
    fill_d      = fill_q;
    tog_d       = tog_q;
    held_d      = held_q;
    blk_valid_d = blk_valid_q && !blk_take_i;
    blk_d       = blk_q;
    if (accept) begin
      fill_d = fill2;
      tog_d  = !tog0;
      held_d = d;
      if (data_done || par_done) begin
        blk_valid_d = 1'b1;
        blk_d       = interleave_on_i ? interleave(blk_src) : blk_src;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      tog_q       <= 1'b0;
      held_q      <= '0;
      blk_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      tog_q       <= tog_d;
      held_q      <= held_d;
      blk_valid_q <= blk_valid_d;
    end
  end

  // Block storage and hand-off data need no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      store_q <= view;
    end
    blk_q <= blk_d;
  end

  assign blk_o       = blk_q;
  assign blk_valid_o = blk_valid_q;

`ifndef SYNTH
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LAST_POS)
    else $error("block fill count out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (blk_valid_q && !blk_take_i) |=> (blk_valid_q && $stable(blk_q)))
    else $error("pending block lost before the sender took it");

  a_take_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_take_i |-> blk_valid_q)
    else $error("sender took a block that was not there");
`endif

endmodule

@@ sv/hfi_send.sv @@
// Drains one block a byte at a time, inserting escape bytes, into the output register.
module hfi_send (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hfi_pkg::cfg_t cfg_i,
  input  hfi_pkg::blk_t blk_i,
  input  logic          blk_valid_i,
  output logic          blk_take_o,
  hfi_out_if.source     out_o
);
  import hfi_pkg::*;

  blk_t      sbuf_q, sbuf_d;
  fill_t     rem_q, rem_d;
  logic      esc_q, esc_d;
  logic      out_valid_q, out_valid_d;
  out_beat_t out_beat_q, out_beat_d;

  logic      advance, hit;
  byte_t     cur;

  assign advance    = !out_valid_q || out_o.ready;
  assign cur        = sbuf_q[0];
  assign hit        = (cur == cfg_i.flag_value) || (cur == cfg_i.reset_value) ||
                      (cur == cfg_i.escape_value);
  assign blk_take_o = (rem_q == '0) && blk_valid_i;

  // Load a new block when idle, otherwise emit one beat whenever the output frees.
  always_comb begin
    sbuf_d      = sbuf_q;
    rem_d       = rem_q;
    esc_d       = esc_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_beat_d  = out_beat_q;
    if (rem_q == '0) begin
      if (blk_valid_i) begin
        sbuf_d = blk_i;
        rem_d  = BLOCK_CNT;
      end
    end else if (advance) begin
      out_valid_d = 1'b1;
      if (hit && !esc_q) begin
        out_beat_d = '{line_byte: cfg_i.escape_value, run_last: 1'b0};
        esc_d      = 1'b1;
      end else begin
        out_beat_d = '{line_byte: cur, run_last: (rem_q == fill_t'(1))};
        esc_d      = 1'b0;
        sbuf_d     = {8'h00, sbuf_q[BLOCK_BYTES-1:1]};
        rem_d      = rem_q - fill_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      esc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      esc_q       <= esc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sbuf_q     <= sbuf_d;
    out_beat_q <= out_beat_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_beat_q;

`ifndef SYNTH
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= BLOCK_CNT)
    else $error("sender byte count out of range");

  a_esc_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> (rem_q != '0))
    else $error("escape pending with no block in flight");

  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (rem_q != '0)) |=> out_valid_q)
    else $error("sender advanced without producing a beat");
`endif

endmodule

@@ sv/hamming_fec_interleave_encoder_top.sv @@
// Top level of the Hamming(12,8) FEC encoder with block interleaver and byte escaping.
//
// Input beats are accepted one per cycle unless the input stalls. Every second byte
// adds a parity byte, and each 12-byte block (8 data, 4 parity) is moved into a hand-off
// register when it completes. The sender then loads it and drains it at one line byte
// per cycle through the output register while the line does not stall: 12 line bytes
// plus one escape byte for each byte that needs one. The single output byte register
// sets the line-side rate. The input stalls only while a finished block waits in the
// hand-off register behind one that is still draining. run_last marks the last byte of
// each block. Configuration must be written only while the block is idle; the block
// itself does not enforce it.
module hamming_fec_interleave_encoder_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  hfi_pkg::cfg_idx_t cfg_idx_i,
  input  hfi_pkg::byte_t    cfg_data_i,
  hfi_in_if.sink            in_i,
  hfi_out_if.source         out_o
);
  import hfi_pkg::*;

  cfg_t cfg_q, cfg_d;
  blk_t blk;
  logic blk_valid, blk_take;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FLAG:   cfg_d.flag_value    = cfg_data_i;
        CFG_RESET:  cfg_d.reset_value   = cfg_data_i;
        CFG_ESCAPE: cfg_d.escape_value  = cfg_data_i;
        CFG_ILV:    cfg_d.interleave_on = cfg_data_i[0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{flag_value: FLAG_RST, reset_value: RESET_RST,
                 escape_value: ESCAPE_RST, interleave_on: ILV_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hfi_fill u_fill (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_i            (in_i),
    .interleave_on_i (cfg_q.interleave_on),
    .blk_o           (blk),
    .blk_valid_o     (blk_valid),
    .blk_take_i      (blk_take)
  );

  hfi_send u_send (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .blk_i       (blk),
    .blk_valid_i (blk_valid),
    .blk_take_o  (blk_take),
    .out_o       (out_o)
  );

endmodule

@@ verif/tb.sv @@
// Testbench for the Hamming FEC interleave encoder: directed and random beats checked by a predictor.
module tb;
  import hfi_pkg::*;

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we_i;
  cfg_idx_t cfg_idx_i;
  byte_t    cfg_data_i;

  hfi_in_if  in_if ();
  hfi_out_if out_if ();

  hamming_fec_interleave_encoder_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Encoder state as the predictor sees it.
  byte_t       blk_mem [BLOCK_BYTES];
  int unsigned blk_fill;
  logic        pair_odd;
  byte_t       pair_first;

  // Register copies.
  byte_t       flag_val;
  byte_t       rst_val;
  byte_t       esc_val;
  logic        ilv_en;

  // Line beats still to come, oldest first.
  out_beat_t   line_beat_q [$];
  int unsigned mismatch_cnt;
  int unsigned gapless_left;

  // Clock.
  initial begin : clk_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Counts a failure and describes the first few of them.
  function automatic void report_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  // Four Hamming check bits of one byte, each the parity of a masked set of data bits.
  function automatic logic [3:0] ham_nibble(byte_t d);
    return {^(d & 8'hF0), ^(d & 8'h8E), ^(d & 8'h6D), ^(d & 8'h5B)};
  endfunction

  // One byte on the line, with an escape in front when it looks like a control byte.
  function automatic void emit_line(byte_t v);
    if (v == flag_val || v == rst_val || v == esc_val) begin
      line_beat_q.push_back(out_beat_t'{line_byte: esc_val, run_last: 1'b0});
    end
    line_beat_q.push_back(out_beat_t'{line_byte: v, run_last: 1'b0});
  endfunction

  // A full block goes out raw or as bit columns.
  function automatic void emit_block();
    byte_t v;
    if (!ilv_en) begin
      for (int k = 0; k < BLOCK_BYTES; k++) emit_line(blk_mem[k]);
      return;
    end
    // Data columns: one line byte per bit position, the first data slot in the MSB.
    for (int b = 7; b >= 0; b--) begin
      v = '0;
      for (int k = 0; k < BLOCK_BYTES; k++) begin
        if (k % 3 != 2) v = {v[6:0], blk_mem[k][b]};
      end
      emit_line(v);
    end
    // Parity columns: a high-nibble bit and its low-nibble partner from each parity slot.
    for (int b = 3; b >= 0; b--) begin
      v = '0;
      for (int k = 2; k < BLOCK_BYTES; k += 3) v = {v[5:0], blk_mem[k][b+4], blk_mem[k][b]};
      emit_line(v);
    end
  endfunction

  function automatic void store_block_byte(byte_t v);
    blk_mem[blk_fill] = v;
    blk_fill++;
    if (blk_fill == BLOCK_BYTES) begin
      emit_block();
      blk_fill = 0;
    end
  endfunction

  // Expected line beats for one accepted input beat; the last of the run is marked.
  function automatic void encode_beat(in_beat_t b);
    int unsigned n_queued;
    out_beat_t   tail;
    n_queued = line_beat_q.size();
    if (b.frame_start) begin
      blk_fill = 0;
      pair_odd = 1'b0;
    end
    store_block_byte(b.data_byte);
    if (pair_odd) begin
      store_block_byte({ham_nibble(b.data_byte), ham_nibble(pair_first)});
    end
    pair_first = b.data_byte;
    pair_odd   = ~pair_odd;
    if (line_beat_q.size() > n_queued) begin
      tail = line_beat_q.pop_back();
      tail.run_last = 1'b1;
      line_beat_q.push_back(tail);
    end
  endfunction

  // Lets the line side empty out, then waits for the sender to settle.
  task automatic drain_line();
    in_if.valid <= 1'b0;
    for (int k = 0; k < 60000 && line_beat_q.size() != 0; k++) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Writes all four registers on consecutive cycles once the encoder is idle.
  task automatic load_settings(byte_t flag_v, byte_t rst_v, byte_t esc_v, byte_t ilv_v);
    cfg_idx_t regs [4];
    byte_t    vals [4];
    regs = '{CFG_FLAG, CFG_RESET, CFG_ESCAPE, CFG_ILV};
    vals = '{flag_v, rst_v, esc_v, ilv_v};
    drain_line();
    for (int k = 0; k < 4; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[k];
      cfg_data_i <= vals[k];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    flag_val = flag_v;
    rst_val  = rst_v;
    esc_val  = esc_v;
    ilv_en   = ilv_v[0];
  endtask

  // Sends one input beat after a random gap; called and returning at a falling edge.
  task automatic send_beat(logic fs, byte_t d);
    int unsigned gap;
    in_beat_t    beat;
    gap = 0;
    if (gapless_left > 0) begin
      gapless_left--;
    end else begin
      case ($urandom_range(0, 19))
        0:                gapless_left = $urandom_range(15, 40);
        1, 2:             gap = $urandom_range(6, 25);
        3, 4, 5, 6, 7, 8: gap = $urandom_range(1, 3);
        default:          gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    beat.data_byte   = d;
    beat.frame_start = fs;
    in_if.valid   <= 1'b1;
    in_if.payload <= beat;
    do @(posedge clk_i); while (!in_if.ready);
    encode_beat(beat);
    @(negedge clk_i);
  endtask

  // Data bytes lean toward the control values and the all-zero and all-one patterns.
  function automatic byte_t pick_data_byte();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 2))
          0:       return flag_val;
          1:       return rst_val;
          default: return esc_val;
        endcase
      end
      1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_traffic(int unsigned n_beats);
    for (int unsigned k = 0; k < n_beats; k++) begin
      send_beat($urandom_range(0, 19) == 0, pick_data_byte());
    end
  endtask

  // One interleaved block under the reset settings, control values and extremes in the data.
  task automatic test_default_block();
    send_beat(1'b1, 8'h00);
    send_beat(1'b0, 8'hFF);
    send_beat(1'b0, FLAG_RST);
    send_beat(1'b0, RESET_RST);
    send_beat(1'b0, ESCAPE_RST);
    send_beat(1'b0, 8'h80);
    send_beat(1'b0, 8'h01);
    send_beat(1'b0, 8'hA5);
  endtask

  // Raw block so that data bytes equal to control values show their escapes.
  // The interleave write carries extra high bits that must be dropped.
  task automatic test_raw_escaping();
    load_settings(FLAG_RST, RESET_RST, ESCAPE_RST, 8'hFE);
    send_beat(1'b0, FLAG_RST);
    send_beat(1'b0, RESET_RST);
    send_beat(1'b0, ESCAPE_RST);
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, 8'hFF);
    send_beat(1'b0, 8'h5A);
    send_beat(1'b0, 8'hC3);
    send_beat(1'b0, 8'h1B);
  endtask

  // All control values the same: one escape per matching byte. A frame start drops
  // the partial block in front of it.
  task automatic test_shared_control_restart();
    load_settings(8'h3C, 8'h3C, 8'h3C, 8'h00);
    send_beat(1'b0, 8'h3C);
    send_beat(1'b0, 8'h11);
    send_beat(1'b0, 8'h3C);
    send_beat(1'b1, 8'h3C);
    send_beat(1'b0, 8'hFF);
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, 8'h3C);
    send_beat(1'b0, 8'h96);
    send_beat(1'b0, 8'h3C);
    send_beat(1'b0, 8'h69);
    send_beat(1'b0, 8'h3C);
  endtask

  // Flag and reset values at the byte extremes, escape 0x55, interleaving on; the interleave write is all ones.
  task automatic test_random_extremes();
    load_settings(8'h00, 8'hFF, 8'h55, 8'hFF);
    random_traffic(70);
  endtask

  task automatic test_random_raw();
    load_settings(byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)),
                  byte_t'($urandom_range(0, 255)), 8'h00);
    random_traffic(60);
  endtask

  task automatic test_random_interleaved();
    load_settings(8'hFF, 8'h00, 8'hAA, 8'h01);
    random_traffic(60);
  endtask

  task automatic test_random_defaults();
    load_settings(FLAG_RST, RESET_RST, ESCAPE_RST, 8'h01);
    random_traffic(55);
  endtask

  // Line side stalls: short and long stops, with long stretches of no stall.
  initial begin : line_stall
    int unsigned run_len;
    logic        rdy;
    out_if.ready = 1'b0;
    forever begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          rdy     = 1'b0;
          run_len = $urandom_range(1, 3);
        end
        3: begin
          rdy     = 1'b0;
          run_len = $urandom_range(8, 40);
        end
        4: begin
          rdy     = 1'b1;
          run_len = $urandom_range(40, 150);
        end
        default: begin
          rdy     = 1'b1;
          run_len = $urandom_range(1, 12);
        end
      endcase
      repeat (run_len) begin
        @(negedge clk_i);
        out_if.ready <= rdy;
      end
    end
  end

  // Each line beat against the oldest expectation.
  always @(posedge clk_i) begin : line_check
    out_beat_t exp_beat;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (line_beat_q.size() == 0) begin
        report_mismatch($sformatf("unexpected line beat %02h last %0b",
                                  out_if.payload.line_byte, out_if.payload.run_last));
      end else begin
        exp_beat = line_beat_q.pop_front();
        if (out_if.payload.line_byte !== exp_beat.line_byte) begin
          report_mismatch($sformatf("line_byte expected %02h actual %02h",
                                    exp_beat.line_byte, out_if.payload.line_byte));
        end
        if (out_if.payload.run_last !== exp_beat.run_last) begin
          report_mismatch($sformatf("run_last expected %0b actual %0b (byte %02h)",
                                    exp_beat.run_last, out_if.payload.run_last,
                                    exp_beat.line_byte));
        end
      end
    end
  end

  // Reset, then the tests in turn, then the verdict.
  initial begin : main_seq
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_FLAG;
    cfg_data_i    = '0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    flag_val      = FLAG_RST;
    rst_val       = RESET_RST;
    esc_val       = ESCAPE_RST;
    ilv_en        = ILV_RST;
    blk_fill      = 0;
    pair_odd      = 1'b0;
    pair_first    = '0;
    mismatch_cnt  = 0;
    gapless_left  = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_default_block();
    test_raw_escaping();
    test_shared_control_restart();
    test_random_extremes();
    test_random_raw();
    test_random_interleaved();
    test_random_defaults();

    drain_line();
    if (line_beat_q.size() != 0) begin
      report_mismatch($sformatf("%0d line beats never arrived", line_beat_q.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
